>>> hdl/hvq_pkg.sv
// Shared types, constants and helpers of the half-vector to unit quaternion block.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package hvq_pkg;

	typedef struct packed {
		logic [15:0] vec_x_half;
		logic [15:0] vec_y_half;
		logic [15:0] vec_z_half;
	} vec_t;

	typedef struct packed {
		logic [31:0] quat_x;
		logic [31:0] quat_y;
		logic [31:0] quat_z;
		logic [31:0] quat_w;
	} quat_t;

	localparam int FX_W    = 83;
	localparam int FX_FRAC = 48;
	localparam logic [FX_W-1:0] FX_ONE = FX_W'(1) << FX_FRAC;

	typedef struct packed {
		logic [7:0]  ex;
		logic [23:0] man;
	} ufl_t;

	typedef struct packed {
		logic [FX_W-1:0] val;
		ufl_t            fl;
	} rnd_t;

	localparam int RND_LAT   = 3;
	localparam int SQRT_BITS = 26;
	localparam int SQRT_LAT  = SQRT_BITS + 2;
	localparam int DIV_BITS  = 25;
	localparam int DIV_LAT   = DIV_BITS + 2;

	localparam logic [31:0] QNAN_NEG  = 32'hffc00000;
	localparam logic [31:0] QUIET_BIT = 32'h00400000;
	localparam logic [4:0]  H_EXP_MAX = 5'h1f;

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0]  e;
		logic [9:0]  f;
		logic [3:0]  p;
		logic [31:0] r;
		e = h[14:10];
		f = h[9:0];
		p = '0;
		for (int i = 0; i < 10; i++) begin
			if (f[i]) p = 4'(i);
		end
		if (e == 5'd0) begin
			if (f == 10'd0) r = {h[15], 31'd0};
			else r = {h[15], 8'(p) + 8'd103, 23'({f, 13'd0} << (4'd10 - p))};
		end else if (e == H_EXP_MAX) begin
			r = {h[15], 8'hff, f, 13'd0};
		end else begin
			r = {h[15], 8'(e) + 8'd112, f, 13'd0};
		end
		return r;
	endfunction

endpackage

>>> hdl/hvq_round.sv
// Three-stage round-to-nearest-even of a fixed-point sum to 24 significant bits.
// Returns the rounded value on the fixed grid and as exponent/significand; uses hvq_pkg.
module hvq_round (
	input  logic                      clk,
	input  logic [hvq_pkg::FX_W-1:0]  val,
	output hvq_pkg::rnd_t             res
);
	localparam int W  = hvq_pkg::FX_W;
	localparam int PW = $clog2(W);

	logic [W-1:0]  v_s1;
	logic [PW-1:0] msb_s1;
	logic [24:0]   r_s2;
	logic [PW-1:0] sh_s2;
	hvq_pkg::rnd_t res_s3;

	logic [PW-1:0] msb_c;
	logic [PW-1:0] sh_c;
	logic [W-1:0]  below_c;
	logic [W-1:0]  half_c;
	logic [23:0]   t_c;
	logic          inc_c;

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < W; i++) begin
			if (val[i]) msb_c = PW'(i);
		end
	end

	always_comb begin
		sh_c    = (msb_s1 > PW'(23)) ? msb_s1 - PW'(23) : '0;
		below_c = v_s1 & ((W'(1) << sh_c) - W'(1));
		half_c  = (sh_c == '0) ? '0 : W'(1) << (sh_c - PW'(1));
		t_c     = 24'(v_s1 >> sh_c);
		inc_c   = (|(below_c & half_c)) & ((|(below_c & ~half_c)) | t_c[0]);
	end

	always_ff @(posedge clk) begin
		v_s1   <= val;
		msb_s1 <= msb_c;
		r_s2   <= {1'b0, t_c} + 25'(inc_c);
		sh_s2  <= sh_c;
		res_s3.val <= W'(r_s2) << sh_s2;
		if (r_s2[24]) begin
			res_s3.fl.man <= r_s2[24:1];
			res_s3.fl.ex  <= 8'(sh_s2) + 8'd103;
		end else begin
			res_s3.fl.man <= r_s2[23:0];
			res_s3.fl.ex  <= 8'(sh_s2) + 8'd102;
		end
	end

	assign res = res_s3;
endmodule

>>> hdl/hvq_sqrt.sv
// Pipelined single-precision square root, one root bit per stage, nearest-even.
// Takes a positive normal value or zero (significand bit 23 clear); uses hvq_pkg.
module hvq_sqrt (
	input  logic          clk,
	input  hvq_pkg::ufl_t arg,
	output logic [31:0]   root
);
	localparam int N    = hvq_pkg::SQRT_BITS;
	localparam int RW   = N + 2;
	localparam int RADW = 2 * N;

	logic [RADW-1:0] rad_q  [0:N];
	logic [RW-1:0]   rem_q  [0:N];
	logic [N-1:0]    root_q [0:N];
	logic [6:0]      hexp_q [0:N];
	logic            zero_q [0:N];
	logic [31:0]     root_s;

	logic [24:0] m25_c;
	logic [23:0] keep_c;
	logic        inc_c;
	logic [24:0] sum_c;
	logic [N-1:0] q_c;

	assign m25_c = arg.ex[0] ? {arg.man, 1'b0} : {1'b0, arg.man};

	always_ff @(posedge clk) begin
		rad_q[0]  <= RADW'({m25_c, 26'd0});
		rem_q[0]  <= '0;
		root_q[0] <= '0;
		hexp_q[0] <= arg.ex[7:1];
		zero_q[0] <= ~arg.man[23];
	end

	genvar k;
	generate
		for (k = 1; k <= N; k++) begin : g_it
			logic [RW+1:0] remx;
			logic [RW+1:0] trial;
			assign remx  = {rem_q[k-1], rad_q[k-1][RADW-1 -: 2]};
			assign trial = {2'b00, root_q[k-1], 2'b01};
			always_ff @(posedge clk) begin
				if (remx >= trial) begin
					rem_q[k]  <= RW'(remx - trial);
					root_q[k] <= {root_q[k-1][N-2:0], 1'b1};
				end else begin
					rem_q[k]  <= RW'(remx);
					root_q[k] <= {root_q[k-1][N-2:0], 1'b0};
				end
				rad_q[k]  <= rad_q[k-1] << 2;
				hexp_q[k] <= hexp_q[k-1];
				zero_q[k] <= zero_q[k-1];
			end
		end
	endgenerate

	always_comb begin
		q_c = root_q[N];
		if (q_c[N-1]) begin
			keep_c = q_c[N-1:2];
			inc_c  = q_c[1] & (q_c[0] | (|rem_q[N]) | keep_c[0]);
		end else begin
			keep_c = q_c[N-2:1];
			inc_c  = q_c[0] & ((|rem_q[N]) | keep_c[0]);
		end
		sum_c = {1'b0, keep_c} + 25'(inc_c);
	end

	always_ff @(posedge clk) begin
		if (zero_q[N]) begin
			root_s <= '0;
		end else begin
			root_s <= {1'b0,
				8'(hexp_q[N]) + (q_c[N-1] ? 8'd64 : 8'd63) + 8'(sum_c[24]),
				sum_c[24] ? 23'd0 : sum_c[22:0]};
		end
	end

	assign root = root_s;
endmodule

>>> hdl/hvq_div.sv
// Pipelined single-precision divide by a positive normal divisor, one quotient bit per stage.
// Dividend is a finite normal or signed zero; rounding is nearest-even; uses hvq_pkg.
module hvq_div (
	input  logic          clk,
	input  logic [31:0]   num,
	input  hvq_pkg::ufl_t den,
	output logic [31:0]   quo
);
	localparam int N = hvq_pkg::DIV_BITS;

	logic [24:0] r_q    [0:N];
	logic [N-1:0] q_q   [0:N];
	logic [23:0] mn_q   [0:N];
	logic [9:0]  e_q    [0:N];
	logic        zero_q [0:N];
	logic        sgn_q  [0:N];
	logic [31:0] quo_s;

	logic        lt_c;
	logic [23:0] keep_c;
	logic        inc_c;
	logic [24:0] sum_c;
	logic [9:0]  ex_c;

	assign lt_c = {1'b1, num[22:0]} < den.man;

	always_ff @(posedge clk) begin
		r_q[0]    <= lt_c ? {1'b1, num[22:0], 1'b0} : {1'b0, 1'b1, num[22:0]};
		q_q[0]    <= '0;
		mn_q[0]   <= den.man;
		e_q[0]    <= {2'b00, num[30:23]} - {2'b00, den.ex} + (lt_c ? 10'd126 : 10'd127);
		zero_q[0] <= (num[30:0] == 31'd0);
		sgn_q[0]  <= num[31];
	end

	genvar k;
	generate
		for (k = 1; k <= N; k++) begin : g_it
			logic        ge;
			logic [24:0] rn;
			assign ge = r_q[k-1] >= {1'b0, mn_q[k-1]};
			assign rn = ge ? r_q[k-1] - {1'b0, mn_q[k-1]} : r_q[k-1];
			always_ff @(posedge clk) begin
				r_q[k]    <= {rn[23:0], 1'b0};
				q_q[k]    <= {q_q[k-1][N-2:0], ge};
				mn_q[k]   <= mn_q[k-1];
				e_q[k]    <= e_q[k-1];
				zero_q[k] <= zero_q[k-1];
				sgn_q[k]  <= sgn_q[k-1];
			end
		end
	endgenerate

	always_comb begin
		keep_c = q_q[N][N-1:1];
		inc_c  = q_q[N][0] & ((|r_q[N]) | keep_c[0]);
		sum_c  = {1'b0, keep_c} + 25'(inc_c);
		ex_c   = e_q[N] + 10'(sum_c[24]);
	end

	always_ff @(posedge clk) begin
		if (zero_q[N]) quo_s <= {sgn_q[N], 31'd0};
		else quo_s <= {sgn_q[N], ex_c[7:0], sum_c[24] ? 23'd0 : sum_c[22:0]};
	end

	assign quo = quo_s;
endmodule

>>> hdl/half_vector_to_unit_quaternion.sv
// Top level: half-precision vector part to unit quaternion, single-precision results.
// Depends on hvq_pkg, hvq_round, hvq_sqrt and hvq_div.
//
//   port   dir  carries                          handshake
//   vec    in   request: x, y, z half patterns   start & !busy
//   quat   out  x, y, z, w single patterns       done, one cycle
//
// One request per cycle; a request's result passes through the two sum roundings,
// the root stage chain and the divide stage chain in series.
// busy stays low: every stage advances on every clock, nothing stalls.
// Reset clears the valid chain and the done flag only; data stages hold whatever they last took.
module half_vector_to_unit_quaternion (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  hvq_pkg::vec_t  vec,
	output logic           done,
	output hvq_pkg::quat_t quat
);
	localparam int W    = hvq_pkg::FX_W;
	localparam int T_A  = 3;
	localparam int T_R1 = T_A + hvq_pkg::RND_LAT;
	localparam int T_V  = T_R1 + 1;
	localparam int T_R2 = T_V + hvq_pkg::RND_LAT;
	localparam int T_D  = T_R2 + 1;
	localparam int T_R3 = T_D + hvq_pkg::RND_LAT;
	localparam int T_W  = T_R3 + hvq_pkg::SQRT_LAT;
	localparam int T_N  = T_R2 + hvq_pkg::SQRT_LAT;
	localparam int T_Q  = T_N + hvq_pkg::DIV_LAT;

	typedef struct packed {
		logic [2:0][31:0] c;
		logic             has_inf;
		logic             has_nan;
		logic [31:0]      nan_w;
	} side_t;

	logic            vld_q  [1:T_Q];
	side_t           side_q [1:T_Q];
	logic            gt_q   [T_D:T_Q];
	logic [31:0]     w_q    [T_W+1:T_Q];
	logic [W-1:0]    p2_q   [T_A:T_R1];
	logic [10:0]     m_s1   [0:2];
	logic [5:0]      sh_s1  [0:2];
	logic [W-1:0]    p_s2   [0:2];
	logic [W-1:0]    a01_s3;
	logic [W-1:0]    v_s7;
	logic [W-1:0]    d_s11;
	logic            done_q;
	hvq_pkg::quat_t  quat_q;

	logic [15:0]     h_c    [0:2];
	side_t           side_c;
	logic [2:0]      nan_c;
	logic [2:0]      inf_c;
	logic [W:0]      diff_c;
	hvq_pkg::rnd_t   r1_res;
	hvq_pkg::rnd_t   r2_res;
	hvq_pkg::rnd_t   r3_res;
	logic [31:0]     n_bits;
	logic [31:0]     w_bits;
	hvq_pkg::ufl_t   n_fl;
	logic [31:0]     quo    [0:2];
	side_t           fin;
	hvq_pkg::quat_t  quat_c;

	assign busy = 1'b0;
	assign h_c[0] = vec.vec_x_half;
	assign h_c[1] = vec.vec_y_half;
	assign h_c[2] = vec.vec_z_half;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			side_c.c[2-i] = hvq_pkg::half_to_single(h_c[i]);
			inf_c[i] = (h_c[i][14:10] == hvq_pkg::H_EXP_MAX) && (h_c[i][9:0] == 10'd0);
			nan_c[i] = (h_c[i][14:10] == hvq_pkg::H_EXP_MAX) && (h_c[i][9:0] != 10'd0);
		end
		side_c.has_inf = |inf_c;
		side_c.has_nan = |nan_c;
		if (nan_c[0]) side_c.nan_w = side_c.c[2] | hvq_pkg::QUIET_BIT;
		else if (nan_c[1]) side_c.nan_w = side_c.c[1] | hvq_pkg::QUIET_BIT;
		else side_c.nan_w = side_c.c[0] | hvq_pkg::QUIET_BIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= T_Q; k++) vld_q[k] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_q[1] <= start & ~busy;
			for (int k = 2; k <= T_Q; k++) vld_q[k] <= vld_q[k-1];
			done_q <= vld_q[T_Q];
		end
	end

	always_ff @(posedge clk) begin
		side_q[1] <= side_c;
		for (int k = 2; k <= T_Q; k++) side_q[k] <= side_q[k-1];
		for (int i = 0; i < 3; i++) begin
			if (h_c[i][14:10] == 5'd0) begin
				m_s1[i]  <= {1'b0, h_c[i][9:0]};
				sh_s1[i] <= '0;
			end else begin
				m_s1[i]  <= {1'b1, h_c[i][9:0]};
				sh_s1[i] <= {h_c[i][14:10], 1'b0} - 6'd2;
			end
			p_s2[i] <= W'({11'd0, m_s1[i]} * {11'd0, m_s1[i]}) << sh_s1[i];
		end
		a01_s3  <= p_s2[0] + p_s2[1];
		p2_q[T_A] <= p_s2[2];
		for (int k = T_A + 1; k <= T_R1; k++) p2_q[k] <= p2_q[k-1];
		v_s7    <= r1_res.val + p2_q[T_R1];
		gt_q[T_D] <= diff_c[W];
		d_s11   <= diff_c[W] ? '0 : diff_c[W-1:0];
		for (int k = T_D + 1; k <= T_Q; k++) gt_q[k] <= gt_q[k-1];
		w_q[T_W+1] <= w_bits;
		for (int k = T_W + 2; k <= T_Q; k++) w_q[k] <= w_q[k-1];
		quat_q  <= quat_c;
	end

	assign diff_c = {1'b0, hvq_pkg::FX_ONE} - {1'b0, r2_res.val};

	hvq_round u_rnd1 (.clk(clk), .val(a01_s3), .res(r1_res));
	hvq_round u_rnd2 (.clk(clk), .val(v_s7), .res(r2_res));
	hvq_round u_rnd3 (.clk(clk), .val(d_s11), .res(r3_res));

	hvq_sqrt u_sqrt_n (.clk(clk), .arg(r2_res.fl), .root(n_bits));
	hvq_sqrt u_sqrt_w (.clk(clk), .arg(r3_res.fl), .root(w_bits));

	assign n_fl.ex  = n_bits[30:23];
	assign n_fl.man = {1'b1, n_bits[22:0]};

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_div
			hvq_div u_div (.clk(clk), .num(side_q[T_N].c[2-g]), .den(n_fl), .quo(quo[g]));
		end
	endgenerate

	always_comb begin
		fin = side_q[T_Q];
		if (fin.has_nan) begin
			quat_c = {fin.c[2], fin.c[1], fin.c[0], fin.nan_w};
		end else if (fin.has_inf) begin
			quat_c.quat_x = (fin.c[2][30:23] == 8'hff) ? hvq_pkg::QNAN_NEG : {fin.c[2][31], 31'd0};
			quat_c.quat_y = (fin.c[1][30:23] == 8'hff) ? hvq_pkg::QNAN_NEG : {fin.c[1][31], 31'd0};
			quat_c.quat_z = (fin.c[0][30:23] == 8'hff) ? hvq_pkg::QNAN_NEG : {fin.c[0][31], 31'd0};
			quat_c.quat_w = '0;
		end else if (gt_q[T_Q]) begin
			quat_c = {quo[0], quo[1], quo[2], w_q[T_Q]};
		end else begin
			quat_c = {fin.c[2], fin.c[1], fin.c[0], w_q[T_Q]};
		end
	end

	assign done = done_q;
	assign quat = quat_q;
endmodule
